[rtl/serial_frame_receiver_crc16_top_assert.svh]
// Assertion macros used by the frame receiver checker.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef SERIAL_FRAME_RECEIVER_CRC16_TOP_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_CRC16_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define SFR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sfr_pkg.sv]
// Types, codes and the CRC-16 byte update for the serial frame receiver.
// No dependencies.
`default_nettype none

package sfr_pkg;

  localparam int KIND_W = 3;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_CRC  = 2'd3
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BODY    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_CRC_ERR = 3'd2,
    KIND_LEN_ERR = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  // input tuser codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // register indexes
  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_CRC_EN  = 2'd2;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // CRC-16/XMODEM, MSB first, one byte
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/serial_frame_receiver_crc16_top.sv]
// Serial frame receiver: header hunt, LE length, body forward, CRC-16/XMODEM check.
// Depends on sfr_pkg.
`default_nettype none
//
//  channel | dir | handshake           | content
//  --------+-----+---------------------+----------------------------------------
//  s_*     | in  | s_tvalid / s_tready | tdata rx_byte, tuser op (0 byte, 1 tick)
//  m_*     | out | m_tvalid / m_tready | tdata body_byte, body_length; tuser kind
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// One word per cycle: every input word is handled in the cycle it is accepted,
// the CRC byte update and phase logic sit between the state registers and the
// single output register, so the sustained rate is one word per clock while m_* does not stall.
// A result appears on m_* the cycle after its input word; words that give no
// result leave the output alone.
// s_tready is high while the output register is empty or being drained, so a
// stall on m_* holds the input back only while a result is waiting.
// rst (synchronous) returns the receiver to header hunting and loads the
// register defaults: header 0x00, timeout 300000 ticks, CRC check on.
// cfg_ready is always high; a write to the unused index is dropped.

module serial_frame_receiver_crc16_top #(
  parameter int BUF_LEN = 512
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output      logic                      s_tready,
  input  wire logic [7:0]                s_tdata,   // [7:0] rx_byte
  input  wire logic                      s_tuser,   // [0] op
  output      logic                      m_tvalid,
  input  wire logic                      m_tready,
  output      logic [23:0]               m_tdata,   // [7:0] body_byte, [16:8] body_length, zero pad
  output      logic [sfr_pkg::KIND_W-1:0] m_tuser,  // [2:0] kind
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [31:0]               cfg_data
);

  import sfr_pkg::*;

  localparam int          LEN_W   = $clog2(BUF_LEN - 4);
  localparam logic [15:0] MAX_LEN = 16'(BUF_LEN - 5);

  // configuration
  logic [7:0]  header_value;
  logic [31:0] timeout_ticks;
  logic        crc_check_enable;

  // receiver state
  phase_t          rx_phase, rx_phase_next;
  logic            second, second_next;          // second length / CRC byte due
  logic [7:0]      length_low, length_low_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] body_count, body_count_next;
  logic [15:0]     running_crc, running_crc_next;
  logic [7:0]      crc_low_byte, crc_low_byte_next;
  logic [31:0]     idle_ticks, idle_ticks_next;

  // result of the current word
  logic            res_valid;
  kind_t           res_kind;
  logic [7:0]      res_byte;
  logic [8:0]      res_len;

  logic            accept;
  logic [7:0]      rx_byte;
  logic [15:0]     crc_step;
  logic [15:0]     len_word;
  logic [15:0]     len_ext;
  logic [15:0]     crc_got;
  logic [31:0]     idle_inc;
  logic [LEN_W-1:0] body_inc;

  assign rx_byte   = s_tdata;
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  assign crc_step = crc_update((rx_phase == PH_HUNT) ? 16'h0000 : running_crc, rx_byte);
  assign len_word = {rx_byte, length_low};
  assign len_ext  = 16'(frame_length);
  assign crc_got  = {rx_byte, crc_low_byte};
  assign idle_inc = (idle_ticks == 32'hFFFF_FFFF) ? idle_ticks : idle_ticks + 32'd1;
  assign body_inc = body_count + LEN_W'(1);

  always_comb begin
    rx_phase_next     = rx_phase;
    second_next       = second;
    length_low_next   = length_low;
    frame_length_next = frame_length;
    body_count_next   = body_count;
    running_crc_next  = running_crc;
    crc_low_byte_next = crc_low_byte;
    idle_ticks_next   = idle_ticks;
    res_valid         = 1'b0;
    res_kind          = KIND_BODY;
    res_byte          = 8'h00;
    res_len           = 9'd0;

    if (s_tuser == OP_TICK) begin
      // ticks only count inside a frame and with the timer enabled
      if (rx_phase != PH_HUNT && timeout_ticks != 32'd0) begin
        idle_ticks_next = idle_inc;
        if (idle_inc >= timeout_ticks) begin
          rx_phase_next   = PH_HUNT;
          second_next     = 1'b0;
          idle_ticks_next = 32'd0;
          res_valid       = 1'b1;
          res_kind        = KIND_TIMEOUT;
        end
      end
    end else begin
      case (rx_phase)
        PH_HUNT: begin
          if (rx_byte == header_value) begin
            running_crc_next = crc_step;
            second_next      = 1'b0;
            idle_ticks_next  = 32'd0;
            rx_phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          idle_ticks_next  = 32'd0;
          running_crc_next = crc_step;
          if (!second) begin
            length_low_next = rx_byte;
            second_next     = 1'b1;
          end else if (len_word > MAX_LEN) begin
            rx_phase_next = PH_HUNT;
            second_next   = 1'b0;
            res_valid     = 1'b1;
            res_kind      = KIND_LEN_ERR;
          end else begin
            frame_length_next = len_word[LEN_W-1:0];
            body_count_next   = '0;
            second_next       = 1'b0;
            rx_phase_next     = (len_word == 16'd0) ? PH_CRC : PH_BODY;
          end
        end
        PH_BODY: begin
          idle_ticks_next  = 32'd0;
          running_crc_next = crc_step;
          body_count_next  = body_inc;
          if (body_inc >= frame_length) begin
            rx_phase_next = PH_CRC;
          end
          res_valid = 1'b1;
          res_kind  = KIND_BODY;
          res_byte  = rx_byte;
        end
        PH_CRC: begin
          idle_ticks_next = 32'd0;
          if (!second) begin
            crc_low_byte_next = rx_byte;
            second_next       = 1'b1;
          end else begin
            rx_phase_next = PH_HUNT;
            second_next   = 1'b0;
            res_valid     = 1'b1;
            res_kind      = (crc_got == running_crc || !crc_check_enable) ? KIND_GOOD
                                                                          : KIND_CRC_ERR;
            res_len       = len_ext[8:0];
          end
        end
        default: begin
          rx_phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value     <= 8'h00;
      timeout_ticks    <= 32'd300000;
      crc_check_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER:  header_value     <= cfg_data[7:0];
        REG_TIMEOUT: timeout_ticks    <= cfg_data;
        REG_CRC_EN:  crc_check_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // receiver state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase     <= PH_HUNT;
      second       <= 1'b0;
      length_low   <= 8'h00;
      frame_length <= '0;
      body_count   <= '0;
      running_crc  <= 16'h0000;
      crc_low_byte <= 8'h00;
      idle_ticks   <= 32'd0;
    end else if (accept) begin
      rx_phase     <= rx_phase_next;
      second       <= second_next;
      length_low   <= length_low_next;
      frame_length <= frame_length_next;
      body_count   <= body_count_next;
      running_crc  <= running_crc_next;
      crc_low_byte <= crc_low_byte_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

  // output register; reloaded whenever a word is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {7'd0, res_len, res_byte};
      m_tuser <= res_kind;
    end
  end

endmodule

`default_nettype wire

[rtl/sfr_checker.sv]
// Port-level checks on the frame receiver, bound to the top level.
// Depends on sfr_pkg and serial_frame_receiver_crc16_top_assert.svh.
`default_nettype none
`include "serial_frame_receiver_crc16_top_assert.svh"

module sfr_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [23:0]                m_tdata,
  input wire logic [sfr_pkg::KIND_W-1:0] m_tuser
);

  import sfr_pkg::*;

  // a held result keeps its word
  `SFR_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // a fresh result always follows an accepted input word
  `SFR_ASSERT_NOW(a_cause, clk, rst, m_tvalid && !$past(m_tvalid), $past(s_tvalid && s_tready), "result without an input word")

  // only body words carry a data byte
  `SFR_ASSERT_NOW(a_byte_zero, clk, rst, m_tvalid && m_tuser != KIND_BODY, m_tdata[7:0] == 8'h00, "data byte on a status word")

  // length only on good or CRC-error words
  `SFR_ASSERT_NOW(a_len_zero, clk, rst, m_tvalid && m_tuser != KIND_GOOD && m_tuser != KIND_CRC_ERR, m_tdata[23:8] == 16'h0000, "length on a word that carries none")

endmodule

bind serial_frame_receiver_crc16_top sfr_checker u_sfr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for serial_frame_receiver_crc16_top: byte/tick words in,
// body bytes and frame verdicts out, checked against an in-bench frame decoder.
// Depends on sfr_pkg and the receiver RTL; nothing else.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int          CLK_PERIOD     = 8;
  localparam int          RESET_CYCLES   = 12;
  localparam int          BUF_LEN        = 512;
  localparam int unsigned MAX_BODY       = BUF_LEN - 5;   // longest legal body
  localparam int unsigned RANDOM_WORDS   = 2000;
  localparam int          PHASES         = 6;
  localparam int          SETTLE         = 4;             // output register latency plus margin
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned FULL_FRAME     = 32'hFFFF_FFFF; // cut point meaning "send it all"
  localparam logic [1:0]  REG_UNUSED     = 2'd3;          // spare index, writes dropped

  // One output word as the decoder expects it.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] body_byte;
    logic [8:0] body_length;
  } frame_event_t;

  // Frame decoder plus the queue of results it still owes.
  class frame_tracker;
    logic [7:0]   header_byte;
    logic [31:0]  tick_limit;
    bit           check_crc;

    phase_t       phase;
    int unsigned  taken;       // bytes of the current frame so far
    logic [7:0]   len_lo;
    int unsigned  body_len;
    logic [15:0]  crc;
    logic [7:0]   crc_lo;
    logic [31:0]  idle;

    frame_event_t pending[$];
    int unsigned  errors;
    int unsigned  tally[5];

    function new();
      header_byte = 8'h00;
      tick_limit  = 32'd300000;
      check_crc   = 1'b1;
      phase       = PH_HUNT;
      taken       = 0;
      len_lo      = 8'h00;
      body_len    = 0;
      crc         = 16'h0000;
      crc_lo      = 8'h00;
      idle        = 32'd0;
      errors      = 0;
      foreach (tally[k]) tally[k] = 0;
    endfunction

    // CRC-16/XMODEM, one input bit at a time, MSB first
    static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
        fb = r[15] ^ b[i];
        r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
    endfunction

    function void restart();
      phase = PH_HUNT;
      taken = 0;
      idle  = 32'd0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_HEADER:  header_byte = v[7:0];
        REG_TIMEOUT: tick_limit  = v;
        REG_CRC_EN:  check_crc   = v[0];
        default: ;
      endcase
    endfunction

    // Advance the decoder by one word; returns 1 when a result is due.
    function bit decode_word(logic op, logic [7:0] b, output frame_event_t ev);
      logic [15:0] len16;
      logic [15:0] rx_crc;
      ev = '0;
      if (op == OP_TICK) begin
        if (phase == PH_HUNT || tick_limit == 32'd0) return 1'b0;
        if (idle != 32'hFFFF_FFFF) idle++;
        if (idle >= tick_limit) begin
          restart();
          ev.kind = KIND_TIMEOUT;
          return 1'b1;
        end
        return 1'b0;
      end
      case (phase)
        PH_HUNT: begin
          if (b == header_byte) begin
            crc   = crc_byte(16'h0000, b);
            taken = 1;
            idle  = 32'd0;
            phase = PH_LEN;
          end
          return 1'b0;
        end
        PH_LEN: begin
          idle = 32'd0;
          crc  = crc_byte(crc, b);
          if (taken < 2) begin
            len_lo = b;
            taken  = 2;
            return 1'b0;
          end
          len16 = {b, len_lo};
          if (len16 > MAX_BODY) begin
            restart();
            ev.kind = KIND_LEN_ERR;
            return 1'b1;
          end
          body_len = 32'(len16);
          taken    = 3;
          phase    = (len16 == 16'd0) ? PH_CRC : PH_BODY;
          return 1'b0;
        end
        PH_BODY: begin
          idle = 32'd0;
          crc  = crc_byte(crc, b);
          taken++;
          if (taken >= body_len + 3) phase = PH_CRC;
          ev.kind      = KIND_BODY;
          ev.body_byte = b;
          return 1'b1;
        end
        default: begin
          idle = 32'd0;
          if (taken == body_len + 3) begin
            crc_lo = b;
            taken++;
            return 1'b0;
          end
          rx_crc = {b, crc_lo};
          ev.kind        = (rx_crc == crc || !check_crc) ? KIND_GOOD : KIND_CRC_ERR;
          ev.body_length = body_len[8:0];
          restart();
          return 1'b1;
        end
      endcase
    endfunction

    function void take_word(logic op, logic [7:0] b);
      frame_event_t ev;
      if (decode_word(op, b, ev)) pending.push_back(ev);
    endfunction

    function void field_check(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_event(logic [KIND_W-1:0] k, logic [23:0] d);
      frame_event_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d data 0x%h",
                 $time, k, d);
        return;
      end
      want = pending.pop_front();
      tally[want.kind]++;
      field_check("kind", want.kind, k);
      field_check("body_byte", want.body_byte, d[7:0]);
      field_check("body_length", want.body_length, d[16:8]);
      field_check("tdata padding", 32'd0, d[23:17]);
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    function void report_leftover();
      if (pending.size() != 0) begin
        errors += pending.size();
        $display("%0t: %0d results never arrived, oldest expected kind %0d byte %0d length %0d",
                 $time, pending.size(), pending[0].kind, pending[0].body_byte,
                 pending[0].body_length);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------- DUT I/O
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata   = 8'h00;   // [7:0] rx_byte
  logic                s_tuser   = OP_BYTE; // [0] op
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [23:0]         m_tdata;             // [7:0] body_byte, [16:8] body_length, pad
  logic [KIND_W-1:0]   m_tuser;             // [2:0] kind
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = 2'd0;
  logic [31:0]         cfg_data  = 32'd0;

  frame_tracker tracker = new();

  int unsigned words_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned gap_rate   = 6;   // 1-in-N chance of a sender gap before a word; 0 = none
  int unsigned stall_rate = 6;   // 1-in-N chance of a receiver stall burst; 0 = none

  serial_frame_receiver_crc16_top #(
    .BUF_LEN (BUF_LEN)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Monitor: everything is sampled at the rising edge, before the RTL's own
  // updates land. The output is checked before the input is noted, though the
  // order does not matter since a result is registered and appears only after its word is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_event(m_tuser, m_tdata);
      if (s_tvalid && s_tready) tracker.take_word(s_tuser, s_tdata);
      if (cfg_valid && cfg_ready) tracker.set_reg(cfg_index, cfg_data);
    end
  end

  // Receiver side: random stall bursts, none when stall_rate is 0.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall == 0 && stall_rate != 0 && $urandom_range(1, stall_rate) == 1)
        stall = $urandom_range(1, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles with no handshake on any channel.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ------------------------------------------------------------ drive tasks

  // One input word; an optional gap goes in front of it.
  // tvalid stays high between back-to-back words.
  task automatic send_word(logic op, logic [7:0] b);
    int unsigned n;
    if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      n = $urandom_range(1, 11);
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Sender holds off until every owed result has come out, then waits out the SETTLE margin.
  task automatic wait_results_done();
    @(negedge clk) s_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // All three registers, with junk in the unused data bits.
  task automatic set_phase(logic [7:0] hdr, logic [31:0] tmo, bit en);
    logic [31:0] junk;
    wait_results_done();
    junk = $urandom;
    write_reg(REG_HEADER, {junk[31:8], hdr});
    write_reg(REG_TIMEOUT, tmo);
    junk = $urandom;
    write_reg(REG_CRC_EN, {junk[31:1], en});
  endtask

  // Builds header, LE length, body and LE CRC, then sends the first `cut`
  // bytes. Oversize lengths stop after the length. fill < 0 gives a random
  // body, else every body byte is fill. Ticks may be slipped in between bytes.
  task automatic send_frame(logic [7:0] hdr, int unsigned len, bit corrupt,
                            int unsigned cut, int unsigned tick_max, int fill);
    logic [7:0]  q[$];
    logic [15:0] crc;
    int unsigned i;
    q = {};
    q.push_back(hdr);
    q.push_back(len[7:0]);
    q.push_back(len[15:8]);
    if (len <= MAX_BODY) begin
      for (i = 0; i < len; i++) q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      crc = 16'h0000;
      foreach (q[j]) crc = frame_tracker::crc_byte(crc, q[j]);
      if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      q.push_back(crc[7:0]);
      q.push_back(crc[15:8]);
    end
    for (i = 0; i < q.size() && i < cut; i++) begin
      if (tick_max != 0 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, tick_max)) send_word(OP_TICK, 8'($urandom));
      send_word(OP_BYTE, q[i]);
    end
  endtask

  // Mostly short bodies; the odd full-size one and some oversize lengths.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 78) return $urandom_range(0, 16);
    if (r < 93) return $urandom_range(17, 80);
    if (r < 94) return MAX_BODY;
    if (r < 95) return $urandom_range(200, MAX_BODY - 1);
    if (r < 99) return $urandom_range(MAX_BODY + 1, 65535);
    return 65535;
  endfunction

  // --------------------------------------------------------------- stimulus
  initial begin
    logic [7:0]  hdr;
    logic [31:0] tmo;
    bit          en;
    int unsigned r;
    int unsigned stop_at;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset register values first: header 0x00, CRC on.
    send_word(OP_TICK, 8'hFF);                        // tick while hunting: ignored
    send_frame(8'h00, 0, 1'b0, FULL_FRAME, 0, -1);    // empty body, good
    send_frame(8'h00, 2, 1'b1, FULL_FRAME, 0, 0);     // header value inside body, bad CRC
    send_frame(8'h00, MAX_BODY + 1, 1'b0, FULL_FRAME, 0, -1);  // just oversize

    // Header 0xFF, CRC check off, timeout after three idle ticks.
    set_phase(8'hFF, 32'd3, 1'b0);
    send_frame(8'hFF, 4, 1'b0, 2, 0, -1);             // stops inside the length
    repeat (3) send_word(OP_TICK, 8'h00);             // reaches the limit exactly
    send_frame(8'hFF, 0, 1'b1, FULL_FRAME, 0, -1);    // bad CRC passes with check off

    // Limit lowered below the idle count already built up.
    wait_results_done();
    write_reg(REG_TIMEOUT, 32'd9);
    send_frame(8'hFF, 0, 1'b0, 3, 0, -1);             // parked in the CRC bytes
    repeat (2) send_word(OP_TICK, 8'h5A);
    wait_results_done();
    write_reg(REG_TIMEOUT, 32'd1);
    send_word(OP_TICK, 8'hA5);                        // idle already past: fires

    // Timeout disabled: ticks inside a frame are ignored. Spare index dropped.
    wait_results_done();
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_UNUSED, $urandom);
    send_word(OP_BYTE, 8'hFF);
    repeat (2) send_word(OP_TICK, 8'h00);

    // Random part: several register settings, extremes included; the last
    // phase runs with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          hdr = 8'($urandom); tmo = $urandom_range(4, 40); en = 1'b1;
          gap_rate = 8; stall_rate = 8;
        end
        1: begin
          hdr = 8'hFF; tmo = 32'd0; en = 1'b1;
          gap_rate = 0; stall_rate = 4;
        end
        2: begin
          hdr = 8'h00; tmo = 32'hFFFF_FFFF; en = 1'b0;
          gap_rate = 3; stall_rate = 0;
        end
        3: begin
          hdr = 8'($urandom); tmo = 32'd1; en = 1'b1;
          gap_rate = 6; stall_rate = 6;
        end
        4: begin
          hdr = 8'($urandom); tmo = $urandom_range(2, 12); en = 1'($urandom);
          gap_rate = 12; stall_rate = 3;
        end
        default: begin
          hdr = 8'($urandom); tmo = $urandom_range(5, 50); en = 1'b1;
          gap_rate = 0; stall_rate = 0;
        end
      endcase
      set_phase(hdr, tmo, en);
      stop_at = words_sent + RANDOM_WORDS / PHASES;
      while (words_sent < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // well-formed frame, sometimes with a damaged CRC
          send_frame(hdr, pick_len(), $urandom_range(0, 5) == 0, FULL_FRAME, 3, -1);
        end else if (r < 80) begin
          // frame cut short, then idle ticks
          send_frame(hdr, pick_len(), 1'b0, $urandom_range(1, 6), 0, -1);
          repeat ($urandom_range(1, 15)) send_word(OP_TICK, 8'($urandom));
        end else if (r < 92) begin
          repeat ($urandom_range(1, 6)) send_word(OP_BYTE, 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 8)) send_word(OP_TICK, 8'($urandom));
        end
      end
    end

    wait_results_done();
    repeat (SETTLE) @(posedge clk);
    tracker.report_leftover();

    $display("Run covered %0d input words and %0d register writes: %0d body bytes, %0d good,",
             words_sent, reg_writes, tracker.tally[KIND_BODY], tracker.tally[KIND_GOOD]);
    $display("%0d CRC-error, %0d length-error and %0d timeout verdicts.",
             tracker.tally[KIND_CRC_ERR], tracker.tally[KIND_LEN_ERR],
             tracker.tally[KIND_TIMEOUT]);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
